// ===== rtl/mmrps_pkg.sv =====
`default_nettype none

package mmrps_pkg;

  // Table depth default
  localparam int MAX_PATHS_DEF = 16;

  // Fixed field widths
  localparam int PATH_IDX_W = 4;
  localparam int RTT_W      = 32;
  localparam int TIME_W     = 48;
  localparam int PIU_W      = 5;
  localparam int PROBE_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [PROBE_W-1:0] PROBE_RESET = PROBE_W'(250000);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_SEND  = 2'd1,
    ACT_PROBE = 2'd2,
    ACT_SENT  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATHS_IN_USE   = 2'd0,
    CFG_PROBE_INTERVAL = 2'd1
  } cfg_reg_t;

  localparam logic PICK_SEND  = 1'b0;
  localparam logic PICK_PROBE = 1'b1;

  typedef struct packed {
    logic demoted;
    logic verified;
    logic present;
  } path_flags_t;

  typedef struct packed {
    path_flags_t        flags;
    logic [RTT_W-1:0]   min_rtt;
    logic [RTT_W-1:0]   srtt;
  } path_entry_t;

  typedef struct packed {
    action_t                 action;
    logic [PATH_IDX_W-1:0]   path_index;
    logic                    path_present;
    logic                    path_verified;
    logic                    path_demoted;
    logic [RTT_W-1:0]        min_rtt_us;
    logic [RTT_W-1:0]        smoothed_rtt_us;
    logic [TIME_W-1:0]       now_us;
  } req_word_t;

  typedef struct packed {
    logic                    pick_kind;
    logic                    path_found;
    logic [PATH_IDX_W-1:0]   chosen_path;
  } rsp_word_t;

  typedef struct packed {
    cfg_reg_t                reg_index;
    logic [CFG_DATA_W-1:0]   wdata;
  } cfg_word_t;

endpackage

`default_nettype wire

// ===== rtl/mmrps_chan_if.sv =====
`default_nettype none

interface mmrps_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mmrps_table.sv =====
`default_nettype none

module mmrps_table
  import mmrps_pkg::*;
#(
  parameter int DEPTH = MAX_PATHS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire path_entry_t              wr_entry,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output path_entry_t                   rd_entry
);

  path_entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld;
  path_entry_t mem_q;
  logic        vld_q;

  // per-entry valid bits stand in for clearing the array
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_addr];
    vld_q <= vld[rd_addr];
  end

  assign rd_entry = vld_q ? mem_q : '0;

endmodule

`default_nettype wire

// ===== rtl/multipath_min_rtt_path_scheduler.sv =====
`default_nettype none
// Send pick: the table scan reads one entry per cycle from memory, starting at
//   entry 0; with no paths in use it answers none without a scan.
// Probe pick: (last + 1) is folded into the active range, then the scan runs.
// Write entry and sent notice act in the accept cycle. One item at a time: the next
//   word is taken from the cycle after the result is loaded; a stall delays that.
// Reset is synchronous: table entries read as absent/zero, registers to defaults.

module multipath_min_rtt_path_scheduler
  import mmrps_pkg::*;
#(
  parameter int MAX_PATHS = MAX_PATHS_DEF
) (
  input wire logic   clk,
  input wire logic   rst,
  mmrps_chan_if.sink   req,
  mmrps_chan_if.source rsp,
  mmrps_chan_if.sink   cfg
);

  localparam int AW = $clog2(MAX_PATHS);          // table address width
  localparam int CW = $clog2(MAX_PATHS + 1);      // path count width
  localparam int LW = (AW > PATH_IDX_W) ? AW : PATH_IDX_W;  // last sent path width
  localparam int RW = (LW + 1 > CW) ? LW + 1 : CW;          // start point fold width

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [PIU_W-1:0]   paths_in_use;
  logic [PROBE_W-1:0] probe_interval;

  // scheduler state outside the table
  logic              last_valid;
  logic [LW-1:0]     last_sent;
  logic [TIME_W-1:0] next_probe;

  // per-item working registers
  logic              kind;
  logic [TIME_W-1:0] now_q;
  logic [RW-1:0]     rem;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     ptr;
  logic              pend;
  logic [AW-1:0]     pend_idx;
  logic              best_found;
  logic [RTT_W-1:0]  low_rtt;
  logic [AW-1:0]     best_idx;
  rsp_word_t         res;

  // output register
  logic      rsp_valid;
  rsp_word_t rsp_data;

  logic [CW-1:0] n_act;
  logic          req_acc;
  logic          wr_en;
  path_entry_t   wr_entry;
  path_entry_t   rd_entry;
  logic          issue;
  logic [AW-1:0] ptr_wrap;
  logic [RTT_W-1:0] eff_rtt;
  logic          sendable;
  logic          better;
  logic          skip;
  logic          probe_hit;
  logic          scan_done;
  logic          rsp_load;
  logic [TIME_W:0]   probe_sum;
  logic [TIME_W-1:0] probe_arm;

  // count above the table depth acts as the full table
  assign n_act = (int'(paths_in_use) > MAX_PATHS) ? CW'(MAX_PATHS) : CW'(paths_in_use);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign req_acc = req.valid && req.ready;

  // entry write goes straight to the table in the accept cycle;
  // an index beyond the table is dropped
  assign wr_en = req_acc && (req.data.action == ACT_WRITE) &&
                 (int'(req.data.path_index) < MAX_PATHS);
  assign wr_entry.flags.present  = req.data.path_present;
  assign wr_entry.flags.verified = req.data.path_verified;
  assign wr_entry.flags.demoted  = req.data.path_demoted;
  assign wr_entry.min_rtt        = req.data.min_rtt_us;
  assign wr_entry.srtt           = req.data.smoothed_rtt_us;

  mmrps_table #(
    .DEPTH (MAX_PATHS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (AW'(req.data.path_index)),
    .wr_entry (wr_entry),
    .rd_addr  (ptr),
    .rd_entry (rd_entry)
  );

  // Scan pipeline: issue address ptr this cycle, evaluate its entry next
  // cycle (pend / pend_idx). A probe stops issuing once a hit is seen.
  assign ptr_wrap = ((CW'(ptr) + CW'(1)) == n_act) ? '0 : ptr + AW'(1);

  assign eff_rtt = (rd_entry.min_rtt != '0) ? rd_entry.min_rtt :
                   (rd_entry.srtt != '0)    ? rd_entry.srtt :
                                              RTT_W'(1);
  assign sendable = rd_entry.flags.present && rd_entry.flags.verified &&
                    !rd_entry.flags.demoted;
  // strict compare keeps the lowest index on ties
  assign better = pend && sendable && (!best_found || (eff_rtt < low_rtt));

  assign skip = (last_valid && (LW'(pend_idx) == last_sent)) || !rd_entry.flags.present;
  assign probe_hit = pend && (kind == PICK_PROBE) && !skip;

  assign issue     = (state == S_SCAN) && (cnt != n_act) && !probe_hit;
  assign scan_done = !pend && (cnt == n_act);

  // result register takes a word when empty or being drained this cycle
  assign rsp_load = (state == S_EMIT) && (!rsp_valid || rsp.ready);

  // next probe time, saturating at the top of the time range
  assign probe_sum = {1'b0, now_q} + (TIME_W + 1)'(probe_interval);
  assign probe_arm = probe_sum[TIME_W] ? '1 : probe_sum[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      paths_in_use   <= '0;
      probe_interval <= PROBE_RESET;
      last_valid     <= 1'b0;
      next_probe     <= '0;
      pend           <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.data.reg_index)
          CFG_PATHS_IN_USE:   paths_in_use   <= cfg.data.wdata[PIU_W-1:0];
          CFG_PROBE_INTERVAL: probe_interval <= cfg.data.wdata[PROBE_W-1:0];
          default: ;
        endcase
      end

      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_acc) begin
            unique case (req.data.action)
              ACT_WRITE: ;
              ACT_SENT: begin
                last_valid <= 1'b1;
                last_sent  <= LW'(req.data.path_index);
              end
              ACT_SEND: begin
                kind             <= PICK_SEND;
                res.pick_kind    <= PICK_SEND;
                res.path_found   <= 1'b0;
                res.chosen_path  <= '0;
                cnt              <= '0;
                ptr              <= '0;
                pend             <= 1'b0;
                best_found       <= 1'b0;
                best_idx         <= '0;
                // no paths in use: answer none, leave last sent alone
                state <= (n_act == '0) ? S_EMIT : S_SCAN;
              end
              ACT_PROBE: begin
                kind            <= PICK_PROBE;
                now_q           <= req.data.now_us;
                res.pick_kind   <= PICK_PROBE;
                res.path_found  <= 1'b0;
                res.chosen_path <= '0;
                rem             <= last_valid ? RW'(last_sent) + RW'(1) : '0;
                if ((n_act <= CW'(1)) || (req.data.now_us < next_probe)) begin
                  state <= S_EMIT;
                end else begin
                  state <= S_START;
                end
              end
              default: ;
            endcase
          end
        end

        // fold (last + 1) into the active range by repeated subtraction
        S_START: begin
          if (rem >= RW'(n_act)) begin
            rem <= rem - RW'(n_act);
          end else begin
            ptr   <= AW'(rem);
            cnt   <= '0;
            pend  <= 1'b0;
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          // issue is low on a probe hit, so this also ends the pipeline
          pend     <= issue;
          pend_idx <= ptr;
          if (issue) begin
            ptr <= ptr_wrap;
            cnt <= cnt + CW'(1);
          end
          if (kind == PICK_SEND) begin
            if (better) begin
              best_found <= 1'b1;
              low_rtt    <= eff_rtt;
              best_idx   <= pend_idx;
            end
            if (scan_done) begin
              // with no sendable path this records path 0
              res.path_found  <= 1'b1;
              res.chosen_path <= PATH_IDX_W'(best_idx);
              last_valid      <= 1'b1;
              last_sent       <= LW'(best_idx);
              state           <= S_EMIT;
            end
          end else begin
            if (probe_hit) begin
              res.path_found  <= 1'b1;
              res.chosen_path <= PATH_IDX_W'(pend_idx);
              next_probe      <= probe_arm;
              state           <= S_EMIT;
            end else if (scan_done) begin
              // every other entry absent: none, timer untouched
              state <= S_EMIT;
            end
          end
        end

        S_EMIT: begin
          if (rsp_load) begin
            rsp_data <= res;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== verif/multipath_min_rtt_path_scheduler_test.sv =====
`timescale 1ns / 100ps

module multipath_min_rtt_path_scheduler_test;
  import mmrps_pkg::*;

  // Idle time before a config write: covers the slowest pick
  // (16-entry scan, overhead, start-point fold) and a table write.
  localparam int SETTLE_CYCLES = 48;

  // Entry flag presets as {present, verified, demoted}
  localparam logic [2:0] E_ABSENT     = 3'b000;
  localparam logic [2:0] E_UNVERIFIED = 3'b100;
  localparam logic [2:0] E_SENDABLE   = 3'b110;
  localparam logic [2:0] E_DEMOTED    = 3'b111;

  // Predicts every pick result from its own copy of the path table and
  // registers, and checks returned words against those predictions in order.
  class min_rtt_pick_board;
    path_flags_t           flags   [MAX_PATHS_DEF];
    logic [RTT_W-1:0]      min_rtt [MAX_PATHS_DEF];
    logic [RTT_W-1:0]      srtt    [MAX_PATHS_DEF];
    bit                    last_valid;
    logic [PATH_IDX_W-1:0] last_path;
    logic [TIME_W-1:0]     next_probe;
    logic [PIU_W-1:0]      paths_in_use;
    logic [PROBE_W-1:0]    probe_interval;
    rsp_word_t             expected_picks[$];
    int unsigned           errors;

    function new();
      foreach (flags[i]) begin
        flags[i]   = '0;
        min_rtt[i] = '0;
        srtt[i]    = '0;
      end
      last_valid     = 1'b0;
      last_path      = '0;
      next_probe     = '0;
      paths_in_use   = '0;
      probe_interval = PROBE_RESET;
      errors         = 0;
    endfunction

    function void set_reg(cfg_word_t c);
      case (c.reg_index)
        CFG_PATHS_IN_USE:   paths_in_use = c.wdata[PIU_W-1:0];
        CFG_PROBE_INTERVAL: probe_interval = c.wdata[PROBE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_picks.size();
    endfunction

    function void note_request(req_word_t w);
      rsp_word_t         r;
      int unsigned       n, i, k;
      bit                hit;
      logic [RTT_W:0]    low_rtt, rtt;
      logic [TIME_W:0]   t;
      n = (paths_in_use > MAX_PATHS_DEF) ? MAX_PATHS_DEF : paths_in_use;
      r = '0;
      case (w.action)
        ACT_WRITE: begin
          flags[w.path_index].present  = w.path_present;
          flags[w.path_index].verified = w.path_verified;
          flags[w.path_index].demoted  = w.path_demoted;
          min_rtt[w.path_index] = w.min_rtt_us;
          srtt[w.path_index]    = w.smoothed_rtt_us;
        end
        ACT_SENT: begin
          last_valid = 1'b1;
          last_path  = w.path_index;
        end
        ACT_SEND: begin
          r.pick_kind = PICK_SEND;
          if (n != 0) begin
            low_rtt = '1;
            for (i = 0; i < n; i++) begin
              if (flags[i].present && flags[i].verified && !flags[i].demoted) begin
                rtt = (min_rtt[i] != 0) ? min_rtt[i] : (srtt[i] != 0) ? srtt[i] : 1;
                if (rtt < low_rtt) begin
                  low_rtt       = rtt;
                  r.chosen_path = i[PATH_IDX_W-1:0];
                end
              end
            end
            r.path_found = 1'b1;
            last_valid   = 1'b1;
            last_path    = r.chosen_path;
          end
          expected_picks.push_back(r);
        end
        default: begin
          r.pick_kind = PICK_PROBE;
          if (n > 1 && w.now_us >= next_probe) begin
            i   = last_valid ? (last_path + 1) % n : 0;
            hit = 1'b0;
            for (k = 0; k < n && !hit; k++) begin
              if (!(last_valid && i == last_path) && flags[i].present) begin
                hit = 1'b1;
                t = w.now_us + probe_interval;
                next_probe    = t[TIME_W] ? '1 : t[TIME_W-1:0];
                r.path_found  = 1'b1;
                r.chosen_path = i[PATH_IDX_W-1:0];
              end else begin
                i = (i + 1 >= n) ? 0 : i + 1;
              end
            end
          end
          expected_picks.push_back(r);
        end
      endcase
    endfunction

    function void check_pick(rsp_word_t got);
      rsp_word_t exp_w;
      if (expected_picks.size() == 0) begin
        $error("unexpected pick word: kind %0d found %0d path %0d",
               got.pick_kind, got.path_found, got.chosen_path);
        errors++;
        return;
      end
      exp_w = expected_picks.pop_front();
      if (got.pick_kind !== exp_w.pick_kind) begin
        $error("pick_kind: expected %0d, actual %0d", exp_w.pick_kind, got.pick_kind);
        errors++;
      end
      if (got.path_found !== exp_w.path_found) begin
        $error("path_found: expected %0d, actual %0d", exp_w.path_found, got.path_found);
        errors++;
      end
      if (got.chosen_path !== exp_w.chosen_path) begin
        $error("chosen_path: expected %0d, actual %0d", exp_w.chosen_path, got.chosen_path);
        errors++;
      end
    endfunction
  endclass

  typedef enum {RX_OPEN, RX_COIN, RX_RUNS} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mmrps_chan_if #(.word_t(req_word_t)) req_if ();
  mmrps_chan_if #(.word_t(rsp_word_t)) rsp_if ();
  mmrps_chan_if #(.word_t(cfg_word_t)) cfg_if ();

  multipath_min_rtt_path_scheduler uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  min_rtt_pick_board board = new();

  // Sender burst state and the running clock fed to probe picks
  int unsigned       burst_left = 0;
  logic [TIME_W-1:0] now_clk = '0;

  // Receiver stall pattern state
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall_left = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side: sample the handshake from values before the edge, then pick
  // the next ready level. Modes switch at random between always ready, coin
  // flip per cycle, or mostly ready with random stall runs.
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      board.check_pick(rsp_if.data);
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(64, 256);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN: rsp_if.ready <= 1'b1;
      RX_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_stall_left != 0) begin
          rx_stall_left--;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0)
            rx_stall_left = $urandom_range(1, 20);
        end
      end
    endcase
  end

  function automatic req_word_t mk(action_t a, logic [PATH_IDX_W-1:0] idx, logic [2:0] pvd,
                                   logic [RTT_W-1:0] mr, logic [RTT_W-1:0] sr,
                                   logic [TIME_W-1:0] now);
    req_word_t w;
    w.action          = a;
    w.path_index      = idx;
    w.path_present    = pvd[2];
    w.path_verified   = pvd[1];
    w.path_demoted    = pvd[0];
    w.min_rtt_us      = mr;
    w.smoothed_rtt_us = sr;
    w.now_us          = now;
    return w;
  endfunction

  // Zeros and small values make ties likely; lowest index must win them.
  function automatic logic [RTT_W-1:0] rand_rtt();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return RTT_W'($urandom_range(1, 8));
      2: return RTT_W'(32'hFFFF_FFFF - $urandom_range(0, 3));
      default: return RTT_W'($urandom);
    endcase
  endfunction

  // Mostly meaningful traffic: entry writes within the active range with
  // good flags, picks, and probes on an advancing clock. About a quarter of
  // writes are noise (any index, any flags).
  function automatic req_word_t rand_request();
    req_word_t   w;
    int unsigned roll, active, step;
    active = (board.paths_in_use > MAX_PATHS_DEF) ? MAX_PATHS_DEF : board.paths_in_use;
    roll   = $urandom_range(0, 99);
    w.path_index      = PATH_IDX_W'($urandom);
    {w.path_present, w.path_verified, w.path_demoted} = 3'($urandom);
    w.min_rtt_us      = rand_rtt();
    w.smoothed_rtt_us = rand_rtt();
    w.now_us          = TIME_W'({$urandom, $urandom});
    if (roll < 35) begin
      w.action = ACT_WRITE;
      if ($urandom_range(0, 3) != 0) begin
        if (active != 0)
          w.path_index = PATH_IDX_W'($urandom_range(0, active - 1));
        w.path_present  = ($urandom_range(0, 7) != 0);
        w.path_verified = ($urandom_range(0, 5) != 0);
        w.path_demoted  = ($urandom_range(0, 4) == 0);
      end
    end else if (roll < 65) begin
      w.action = ACT_SEND;
    end else if (roll < 85) begin
      w.action = ACT_PROBE;
      step = board.probe_interval + board.probe_interval / 2 + 8;
      now_clk += $urandom_range(0, step);
      w.now_us = now_clk;
      // occasionally a probe from the past
      if ($urandom_range(0, 9) == 0)
        w.now_us = now_clk - $urandom_range(0, 1000);
    end else begin
      w.action = ACT_SENT;
      if (active != 0 && $urandom_range(0, 3) != 0)
        w.path_index = PATH_IDX_W'($urandom_range(0, active - 1));
    end
    return w;
  endfunction

  // Offer one word, hold it until accepted, then maybe open a gap.
  task automatic push_req(input req_word_t w);
    int unsigned gap;
    req_if.valid <= 1'b1;
    req_if.data  <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    board.note_request(w);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drain: every pick answered, then room for a trailing write to finish.
  task automatic settle();
    req_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_word_t c;
    settle();
    c.reg_index = idx;
    c.wdata     = val;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    board.set_reg(c);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int                    paths_plan [8];
    logic [PROBE_W-1:0]    gap_plan   [8];
    logic [CFG_DATA_W-1:0] pv;
    int                    ph, j;

    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // No paths in use yet: send pick answers none, probe is not allowed.
    push_req(mk(ACT_SEND, 4'd0, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, '0));
    // Table: entry 0 has no RTT known (counts as 1), entry 1 the largest min
    // RTT, entry 2 demoted, entry 3 unverified, entry 15 all flags and ones.
    push_req(mk(ACT_WRITE, 4'd0, E_SENDABLE, '0, '0, '0));
    push_req(mk(ACT_WRITE, 4'd1, E_SENDABLE, 32'hFFFF_FFFF, 32'd3, '0));
    push_req(mk(ACT_WRITE, 4'd2, E_DEMOTED, 32'd1, 32'd1, '0));
    push_req(mk(ACT_WRITE, 4'd3, E_UNVERIFIED, 32'd2, '0, '0));
    push_req(mk(ACT_WRITE, 4'd15, E_DEMOTED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
    push_req(mk(ACT_WRITE, 4'd4, E_SENDABLE, '0, 32'd7, '0));

    // Single path: probe refused even though the timer allows it.
    write_cfg(CFG_PATHS_IN_USE, 24'd1);
    write_cfg(CFG_PROBE_INTERVAL, 24'hFF_FFFF);
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, 48'h0000_0001_0000));
    push_req(mk(ACT_SEND, 4'd0, E_ABSENT, '0, '0, '0));

    write_cfg(CFG_PATHS_IN_USE, 24'd5);
    push_req(mk(ACT_SEND, 4'd0, E_ABSENT, '0, '0, '0));
    // entry 0 falls back to its smoothed RTT of 9, so entry 4 (7) wins
    push_req(mk(ACT_WRITE, 4'd0, E_SENDABLE, '0, 32'd9, '0));
    push_req(mk(ACT_SEND, 4'd0, E_ABSENT, '0, '0, '0));
    // probe wraps from the entry after last sent; then one refused as too early
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, 48'h10));
    // last sent beyond the active range still sets the start point
    push_req(mk(ACT_SENT, 4'd12, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, 48'h100_0000));
    // every other entry absent: probe finds nothing, timer stays
    push_req(mk(ACT_WRITE, 4'd1, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_WRITE, 4'd2, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_WRITE, 4'd3, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_WRITE, 4'd4, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_SENT, 4'd0, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, 48'h200_0000));
    // nothing sendable: send pick falls back to path 0
    push_req(mk(ACT_WRITE, 4'd0, E_DEMOTED, 32'd5, 32'd5, '0));
    push_req(mk(ACT_SEND, 4'd0, E_ABSENT, '0, '0, '0));

    write_cfg(CFG_PROBE_INTERVAL, 24'd0);
    write_cfg(CFG_PATHS_IN_USE, 24'd16);
    push_req(mk(ACT_SEND, 4'd0, E_ABSENT, '0, '0, '0));

    // ---- random part ----
    // Per phase: path count (31 acts as the full table) and probe interval.
    paths_plan = '{2, 16, 31, 1, 3, 0, 8, 16};
    gap_plan   = '{24'd0, 24'hFF_FFFF, 24'd1000, 24'd0, 24'd250000, 24'd7, 24'd0, 24'd100};
    paths_plan[5] = $urandom_range(0, 31);
    gap_plan[3]   = PROBE_W'($urandom);
    gap_plan[6]   = PROBE_W'($urandom_range(1, 5000));
    // start the probe clock past whatever the directed probes armed
    now_clk = 48'h400_0000;
    for (ph = 0; ph < 8; ph++) begin
      // upper data bits are don't-care for the path count register
      pv = CFG_DATA_W'($urandom);
      pv[PIU_W-1:0] = PIU_W'(paths_plan[ph]);
      write_cfg(CFG_PATHS_IN_USE, pv);
      write_cfg(CFG_PROBE_INTERVAL, gap_plan[ph]);
      for (j = 0; j < 140; j++)
        push_req(rand_request());
    end

    // ---- timer saturation at the top of the time range ----
    write_cfg(CFG_PROBE_INTERVAL, 24'hFF_FFFF);
    write_cfg(CFG_PATHS_IN_USE, 24'd16);
    push_req(mk(ACT_WRITE, 4'd5, E_SENDABLE, 32'd3, 32'd3, '0));
    push_req(mk(ACT_WRITE, 4'd9, E_UNVERIFIED, 32'd4, 32'd4, '0));
    push_req(mk(ACT_SENT, 4'd5, E_ABSENT, '0, '0, '0));
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, 48'hFFFF_FFFF_FFFF));
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, 48'hFFFF_FFFF_FFFF));
    push_req(mk(ACT_PROBE, 4'd0, E_ABSENT, '0, '0, 48'hFFFF_FFFF_FFFE));

    settle();
    if (board.errors == 0 && board.pending() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
